// File: src/srsd_pkg.sv
// Shared types and constants for the serial reset and sync detector.
package srsd_pkg;

  localparam logic [7:0] ResetByte = 8'h83;
  localparam logic [7:0] SyncLead  = 8'h80;
  localparam logic [7:0] SyncOne   = 8'h01;
  localparam logic [7:0] SyncSum   = 8'hFF;

  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [CfgIdxBits-1:0] CFG_SLOW_GAP = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_FAST_GAP = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_SYNC_EN  = 2'd2;

  localparam logic [15:0] SlowGapRst = 16'd250;
  localparam logic [15:0] FastGapRst = 16'd10;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_NATIVE = 2'd1;
  localparam logic [1:0] EV_SYNC   = 2'd2;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_NATIVE = 2'd1;
  localparam logic [1:0] MODE_SYNC   = 2'd2;

  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrBits = 1;
  localparam int unsigned QCntBits = 2;

  // One classified byte, as handed from front to back.
  typedef struct packed {
    logic [7:0] data;      // the input byte itself
    logic [7:0] replay;    // X of the sync sequence (previous byte)
    logic [1:0] ev;
    logic       mc;
    logic       sync;      // expand into four results
  } entry_t;

endpackage

// File: src/srsd_front.sv
// Front end: config registers, pattern detection state, classification of each byte.
module srsd_front #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [srsd_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  logic [srsd_pkg::CfgDataBits-1:0]     cfg_data_i,
  input  logic                                 accept_i,
  input  logic [7:0]                           byte_in_i,
  input  logic [TIME_BITS-1:0]                 time_ms_i,
  output srsd_pkg::entry_t                     entry_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ONE  = 2'd1;
  localparam logic [1:0] PH_X    = 2'd2;
  localparam logic [1:0] CntMax  = 2'd2;

  logic [15:0]          slow_gap_q, fast_gap_q;
  logic                 sync_en_q;
  logic [7:0]           last_byte_q, last_byte_d;
  logic [TIME_BITS-1:0] last_time_q, last_time_d;
  logic [1:0]           pair_q, pair_d;
  logic [1:0]           phase_q, phase_d;
  logic [1:0]           seq_q, seq_d;
  logic [1:0]           mode_q, mode_d;

  logic [TIME_BITS-1:0] gap;
  logic                 fast, slow, sum_ok;
  logic [1:0]           ev;
  logic                 mc, sync_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_gap_q <= srsd_pkg::SlowGapRst;
      fast_gap_q <= srsd_pkg::FastGapRst;
      sync_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        srsd_pkg::CFG_SLOW_GAP: slow_gap_q <= cfg_data_i;
        srsd_pkg::CFG_FAST_GAP: fast_gap_q <= cfg_data_i;
        srsd_pkg::CFG_SYNC_EN:  sync_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign gap    = time_ms_i - last_time_q;
  assign fast   = gap < TIME_BITS'(fast_gap_q);
  assign slow   = gap > TIME_BITS'(slow_gap_q);
  assign sum_ok = 8'(last_byte_q + byte_in_i + srsd_pkg::SyncOne + srsd_pkg::SyncLead)
                  == srsd_pkg::SyncSum;

  always_comb begin
    last_byte_d = byte_in_i;
    last_time_d = time_ms_i;
    pair_d      = pair_q;
    phase_d     = phase_q;
    seq_d       = seq_q;
    mode_d      = mode_q;
    ev          = srsd_pkg::EV_NONE;
    mc          = 1'b0;
    sync_fire   = 1'b0;

    if (byte_in_i == srsd_pkg::ResetByte && phase_q == PH_IDLE) begin
      if (last_byte_q == srsd_pkg::ResetByte && slow) begin
        if (pair_q < CntMax) pair_d = pair_q + 2'd1;
        if (pair_d == CntMax) begin
          ev     = srsd_pkg::EV_NATIVE;
          mc     = (mode_q != srsd_pkg::MODE_NATIVE);
          mode_d = srsd_pkg::MODE_NATIVE;
        end
      end else begin
        pair_d = 2'd0;
      end
    end else begin
      priority if (phase_q == PH_X && fast && sum_ok) begin
        if (seq_q < CntMax) seq_d = seq_q + 2'd1;
        phase_d = PH_IDLE;
      end else if (byte_in_i == srsd_pkg::SyncOne && last_byte_q == srsd_pkg::SyncLead &&
                   phase_q == PH_IDLE && fast) begin
        phase_d = PH_ONE;
      end else if (byte_in_i != 8'd0 && phase_q == PH_ONE && fast) begin
        phase_d = PH_X;
      end else if (phase_q != PH_IDLE) begin
        seq_d   = 2'd0;
        phase_d = PH_IDLE;
      end else begin
        phase_d = phase_q;
      end
      if (seq_d == CntMax && sync_en_q) begin
        phase_d   = PH_IDLE;
        pair_d    = 2'd0;
        seq_d     = 2'd0;
        ev        = srsd_pkg::EV_SYNC;
        mc        = (mode_q != srsd_pkg::MODE_SYNC);
        mode_d    = srsd_pkg::MODE_SYNC;
        sync_fire = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_byte_q <= '0;
      last_time_q <= '0;
      pair_q      <= '0;
      phase_q     <= PH_IDLE;
      seq_q       <= '0;
      mode_q      <= srsd_pkg::MODE_NONE;
    end else if (accept_i) begin
      last_byte_q <= last_byte_d;
      last_time_q <= last_time_d;
      pair_q      <= pair_d;
      phase_q     <= phase_d;
      seq_q       <= seq_d;
      mode_q      <= mode_d;
    end
  end

  assign entry_o.data   = byte_in_i;
  assign entry_o.replay = last_byte_q;
  assign entry_o.ev     = ev;
  assign entry_o.mc     = mc;
  assign entry_o.sync   = sync_fire;

endmodule

// File: src/srsd_queue.sv
// Two-entry queue of classified bytes between front and back.
module srsd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  srsd_pkg::entry_t push_entry_i,
  input  logic             pop_i,
  output srsd_pkg::entry_t head_o,
  output logic             full_o,
  output logic             avail_o
);

  srsd_pkg::entry_t                 mem_q [srsd_pkg::QDepth];
  logic [srsd_pkg::QPtrBits-1:0]    wr_ptr_q, rd_ptr_q;
  logic [srsd_pkg::QCntBits-1:0]    cnt_q, cnt_d;

  assign full_o  = cnt_q == srsd_pkg::QCntBits'(srsd_pkg::QDepth);
  assign avail_o = cnt_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: src/srsd_back.sv
// Back end: holds one entry and emits its results, four beats for a sync reset.
module srsd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  srsd_pkg::entry_t head_i,
  input  logic             avail_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       byte_out_o,
  output logic [1:0]       event_res_o,
  output logic             mode_changed_o,
  output logic             last_o
);

  localparam logic [1:0] BEAT_LEAD   = 2'd0;
  localparam logic [1:0] BEAT_ONE    = 2'd1;
  localparam logic [1:0] BEAT_REPLAY = 2'd2;
  localparam logic [1:0] BEAT_FINAL  = 2'd3;

  srsd_pkg::entry_t cur_q;
  logic             cur_valid_q;
  logic [1:0]       beat_q;
  logic             out_take, final_beat, load;

  assign out_take   = cur_valid_q && !out_stall_i;
  assign final_beat = !cur_q.sync || beat_q == BEAT_FINAL;
  assign load       = !cur_valid_q || (out_take && final_beat);
  assign pop_o      = load && avail_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      beat_q      <= BEAT_LEAD;
    end else if (load) begin
      cur_valid_q <= avail_i;
      beat_q      <= BEAT_LEAD;
    end else if (out_take) begin
      beat_q <= beat_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
  end

  always_comb begin
    byte_out_o     = cur_q.data;
    event_res_o    = cur_q.ev;
    mode_changed_o = cur_q.mc;
    last_o         = 1'b1;
    if (cur_q.sync) begin
      event_res_o    = srsd_pkg::EV_NONE;
      mode_changed_o = 1'b0;
      last_o         = 1'b0;
      unique case (beat_q)
        BEAT_LEAD: begin
          byte_out_o     = srsd_pkg::SyncLead;
          event_res_o    = cur_q.ev;
          mode_changed_o = cur_q.mc;
        end
        BEAT_ONE:    byte_out_o = srsd_pkg::SyncOne;
        BEAT_REPLAY: byte_out_o = cur_q.replay;
        BEAT_FINAL: begin
          byte_out_o = cur_q.data;
          last_o     = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = cur_valid_q;

endmodule

// File: src/serial_reset_sync_detector.sv
// Top level of the serial reset and sync detector.
//
//  channel | direction | handshake                   | payload
//  in      | input     | in_valid_i / in_stall_o     | byte_in_i, time_ms_i
//  out     | output    | out_valid_o / out_stall_i   | byte_out_o, event_res_o,
//          |           |                             | mode_changed_o, last_o
//  cfg     | input     | cfg_we_i (no wait)          | cfg_idx_i, cfg_data_i
//
// One byte accepted per cycle while the queue is not full; detection state
// updates in the accept cycle. A result is registered in the queue and then in
// the back end; a sync reset fills the output for four beats, limiting rate.
// The two-entry queue lets input flow on while output is stalled, until full.
// Reset clears all detection state and loads the register defaults.
module serial_reset_sync_detector #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [srsd_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [srsd_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       byte_in_i,
  input  logic [TIME_BITS-1:0]             time_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       byte_out_o,
  output logic [1:0]                       event_res_o,
  output logic                             mode_changed_o,
  output logic                             last_o
);

  srsd_pkg::entry_t front_entry, head;
  logic             accept, q_full, q_avail, pop;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  srsd_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .accept_i (accept),
    .byte_in_i, .time_ms_i,
    .entry_o  (front_entry)
  );

  srsd_queue u_queue (
    .clk_i, .rst_ni,
    .push_i       (accept),
    .push_entry_i (front_entry),
    .pop_i        (pop),
    .head_o       (head),
    .full_o       (q_full),
    .avail_o      (q_avail)
  );

  srsd_back u_back (
    .clk_i, .rst_ni,
    .head_i  (head),
    .avail_i (q_avail),
    .pop_o   (pop),
    .out_valid_o, .out_stall_i, .byte_out_o, .event_res_o, .mode_changed_o, .last_o
  );

endmodule

// File: src/srsd_chk.sv
// Port-level checks for the serial reset and sync detector, bound to the top level.
module srsd_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] byte_out_o,
  input logic [1:0] event_res_o,
  input logic       mode_changed_o,
  input logic       last_o
);

  // a stalled output transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_out_o) &&
    $stable(event_res_o) && $stable(mode_changed_o) && $stable(last_o))
    else $error("stalled output changed");

  // sync reset opens with the lead byte and is never the final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == srsd_pkg::EV_SYNC |->
    !last_o && byte_out_o == srsd_pkg::SyncLead)
    else $error("bad sync reset head");

  // replay continues right after the lead byte is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && event_res_o == srsd_pkg::EV_SYNC |=>
    out_valid_o && byte_out_o == srsd_pkg::SyncOne && !last_o &&
    event_res_o == srsd_pkg::EV_NONE)
    else $error("sync replay broken");

  // mode change only comes with an event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_changed_o |-> event_res_o != srsd_pkg::EV_NONE)
    else $error("mode change without event");

endmodule

bind serial_reset_sync_detector srsd_chk u_srsd_chk (.*);

// File: verif/srsd_checker.sv
// Checker for the serial reset and sync detector: predicts results and compares them.
module srsd_checker #(
  parameter int unsigned TimeBits = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [srsd_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [srsd_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [7:0]                       byte_in_i,
  input  logic [TimeBits-1:0]              time_ms_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [7:0]                       byte_out_i,
  input  logic [1:0]                       event_res_i,
  input  logic                             mode_changed_i,
  input  logic                             last_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] ev;
    logic       mc;
    logic       fin;
  } result_t;

  localparam logic [1:0] SyncIdle   = 2'd0;
  localparam logic [1:0] SyncGotOne = 2'd1;
  localparam logic [1:0] SyncGotX   = 2'd2;

  logic [15:0]         slow_gap;
  logic [15:0]         fast_gap;
  logic                sync_en;
  logic [7:0]          prev_byte;
  logic [TimeBits-1:0] prev_time;
  logic [1:0]          slow_pairs;
  logic [1:0]          sync_step;
  logic [1:0]          sync_seen;
  logic [1:0]          cur_mode;

  result_t pending_results[$];
  int      mismatch_count = 0;

  // Update detection state for one byte and queue the results it causes.
  task automatic classify_byte(input logic [7:0] b, input logic [TimeBits-1:0] t);
    logic [TimeBits-1:0] gap;
    logic                fast;
    logic [1:0]          ev;
    logic                mc;
    logic [7:0]          sum;
    gap = t - prev_time;
    fast = gap < fast_gap;
    ev = srsd_pkg::EV_NONE;
    mc = 1'b0;
    sum = prev_byte + b + srsd_pkg::SyncOne + srsd_pkg::SyncLead;
    if (b == srsd_pkg::ResetByte && sync_step == SyncIdle) begin
      if (prev_byte == srsd_pkg::ResetByte && gap > slow_gap) begin
        if (slow_pairs < 2) slow_pairs++;
        if (slow_pairs > 1) begin
          ev = srsd_pkg::EV_NATIVE;
          mc = (cur_mode != srsd_pkg::MODE_NATIVE);
          cur_mode = srsd_pkg::MODE_NATIVE;
        end
      end else begin
        slow_pairs = '0;
      end
    end else begin
      if (sync_step == SyncGotX && fast && sum == srsd_pkg::SyncSum) begin
        if (sync_seen < 2) sync_seen++;
        sync_step = SyncIdle;
      end else if (b == srsd_pkg::SyncOne && prev_byte == srsd_pkg::SyncLead &&
                   sync_step == SyncIdle && fast) begin
        sync_step = SyncGotOne;
      end else if (b != 8'h00 && sync_step == SyncGotOne && fast) begin
        sync_step = SyncGotX;
      end else if (sync_step != SyncIdle) begin
        sync_seen = '0;
        sync_step = SyncIdle;
      end
      if (sync_seen > 1 && sync_en) begin
        sync_step = SyncIdle;
        slow_pairs = '0;
        sync_seen = '0;
        mc = (cur_mode != srsd_pkg::MODE_SYNC);
        cur_mode = srsd_pkg::MODE_SYNC;
        // replay of the sequence head goes out ahead of the byte itself
        pending_results.push_back({srsd_pkg::SyncLead, srsd_pkg::EV_SYNC, mc, 1'b0});
        pending_results.push_back({srsd_pkg::SyncOne, srsd_pkg::EV_NONE, 1'b0, 1'b0});
        pending_results.push_back({prev_byte, srsd_pkg::EV_NONE, 1'b0, 1'b0});
        mc = 1'b0;
      end
    end
    prev_time = t;
    prev_byte = b;
    pending_results.push_back({b, ev, mc, 1'b1});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t want;
    result_t got;
    if (!rst_ni) begin
      slow_gap = srsd_pkg::SlowGapRst;
      fast_gap = srsd_pkg::FastGapRst;
      sync_en = 1'b0;
      prev_byte = '0;
      prev_time = '0;
      slow_pairs = '0;
      sync_step = SyncIdle;
      sync_seen = '0;
      cur_mode = srsd_pkg::MODE_NONE;
      pending_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          srsd_pkg::CFG_SLOW_GAP: slow_gap = cfg_data_i;
          srsd_pkg::CFG_FAST_GAP: fast_gap = cfg_data_i;
          srsd_pkg::CFG_SYNC_EN:  sync_en = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got = {byte_out_i, event_res_i, mode_changed_i, last_i};
        if (pending_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result byte=%02h ev=%0d mc=%0b last=%0b",
                     $time, got.data, got.ev, got.mc, got.fin);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10)
              $display({"%0t: mismatch exp byte=%02h ev=%0d mc=%0b last=%0b",
                        " got byte=%02h ev=%0d mc=%0b last=%0b"}, $time,
                       want.data, want.ev, want.mc, want.fin,
                       got.data, got.ev, got.mc, got.fin);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) classify_byte(byte_in_i, time_ms_i);
    end
    pending_o = pending_results.size();
    fail_count_o = mismatch_count;
  end

endmodule

// File: verif/tb_top.sv
// Testbench top for the serial reset and sync detector: stimulus, idling and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [srsd_pkg::CfgIdxBits-1:0]  cfg_idx = srsd_pkg::CFG_SLOW_GAP;
  logic [srsd_pkg::CfgDataBits-1:0] cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [7:0]                       byte_in = '0;
  logic [31:0]                      time_ms = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [7:0]                       byte_out;
  logic [1:0]                       event_res;
  logic                             mode_changed;
  logic                             result_last;

  int          fail_count;
  int          pending;
  int          sent = 0;
  logic        settled = 1'b0;
  logic [31:0] now_ms = '0;
  logic [15:0] slow_ms = srsd_pkg::SlowGapRst;
  logic [15:0] fast_ms = srsd_pkg::FastGapRst;

  always #5 clk = ~clk;

  serial_reset_sync_detector dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .byte_in_i      (byte_in),
    .time_ms_i      (time_ms),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .byte_out_o     (byte_out),
    .event_res_o    (event_res),
    .mode_changed_o (mode_changed),
    .last_o         (result_last)
  );

  srsd_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .byte_in_i      (byte_in),
    .time_ms_i      (time_ms),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .byte_out_i     (byte_out),
    .event_res_i    (event_res),
    .mode_changed_i (mode_changed),
    .last_i         (result_last),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver back-pressure in bursts, off once the run has settled.
  initial begin
    forever begin
      if (!settled && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 4) == 0 ? $urandom_range(15, 40) : $urandom_range(1, 6))
        @(negedge clk);
    end
  end

  function automatic logic [31:0] fast_dt();
    return (fast_ms == 0) ? 32'd0 : 32'($urandom_range(0, fast_ms - 1));
  endfunction

  function automatic logic [31:0] noise_dt();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 20);
      1: return $urandom_range(0, 3000);
      2: return $urandom_range(0, 70000);
      default: return $urandom;
    endcase
  endfunction

  // One input transaction, dt ms after the previous byte; returns at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic [31:0] dt);
    if (!settled && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    now_ms = now_ms + dt;
    in_valid <= 1'b1;
    byte_in <= b;
    time_ms <= now_ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_sync(input logic [7:0] x, input logic [7:0] y);
    send_byte(srsd_pkg::SyncLead, noise_dt());
    send_byte(srsd_pkg::SyncOne, fast_dt());
    send_byte(x, fast_dt());
    send_byte(y, fast_dt());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] slow, input logic [15:0] fast, input logic en);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= srsd_pkg::CFG_SLOW_GAP;
    cfg_data <= slow;
    @(negedge clk);
    cfg_idx <= srsd_pkg::CFG_FAST_GAP;
    cfg_data <= fast;
    @(negedge clk);
    cfg_idx <= srsd_pkg::CFG_SYNC_EN;
    cfg_data <= srsd_pkg::CfgDataBits'(en);
    @(negedge clk);
    cfg_we <= 1'b0;
    slow_ms = slow;
    fast_ms = fast;
  endtask

  initial begin
    int         base;
    int         ph;
    int         kind;
    logic [7:0] x;
    logic [7:0] y;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Register defaults after reset: slow 250, fast 10, sync switch off.
    send_byte(8'h00, 0);
    send_byte(8'hFF, 5);
    send_byte(srsd_pkg::ResetByte, 1);
    repeat (3) send_byte(srsd_pkg::ResetByte, 251);  // last one is a repeated native reset
    send_byte(srsd_pkg::ResetByte, 250);             // gap equal to the limit breaks the pair
    // 0x83 taken as the X byte of a sync sequence, gaps one below the limit
    send_byte(srsd_pkg::SyncLead, 9);
    send_byte(srsd_pkg::SyncOne, 9);
    send_byte(srsd_pkg::ResetByte, 9);
    send_byte(8'hFB, 9);
    send_sync(8'h10, 8'h6E);               // second sync, no permission yet
    send_byte(8'h55, 20);
    set_config(srsd_pkg::SlowGapRst, srsd_pkg::FastGapRst, 1'b1);
    send_byte(8'h42, 20);                  // pending syncs fire now
    // native reset across the time wrap
    send_byte(srsd_pkg::ResetByte, 32'hFFFF_FFF0 - now_ms);
    send_byte(srsd_pkg::ResetByte, 32'h220);
    send_byte(srsd_pkg::ResetByte, 300);

    base = sent;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_config(srsd_pkg::SlowGapRst, srsd_pkg::FastGapRst, 1'b1);
        1: set_config(16'd0, 16'hFFFF, 1'b0);
        2: set_config(16'hFFFF, 16'd0, 1'b1);
        3: set_config(16'($urandom_range(0, 1000)), 16'($urandom_range(1, 50)),
                      1'($urandom_range(0, 1)));
        default: set_config(16'd100, 16'd20, 1'b1);
      endcase
      settled = (ph == 4);
      while (sent < base + 62 * (ph + 1)) begin
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
          x = 8'($urandom_range(1, 255));
          send_sync(x, srsd_pkg::SyncSum - srsd_pkg::SyncLead - srsd_pkg::SyncOne - x);
        end else if (kind < 6) begin
          repeat ($urandom_range(2, 4))
            send_byte(srsd_pkg::ResetByte, slow_ms + 32'd1 + $urandom_range(0, 2000));
        end else if (kind == 6) begin
          x = 8'($urandom);
          y = srsd_pkg::SyncSum - srsd_pkg::SyncLead - srsd_pkg::SyncOne - x;
          case ($urandom_range(0, 2))
            0: send_sync(x, y + 8'($urandom_range(1, 255)));
            1: send_sync(8'h00, y);
            default: begin
              // too slow on the closing byte
              send_byte(srsd_pkg::SyncLead, noise_dt());
              send_byte(srsd_pkg::SyncOne, fast_dt());
              send_byte(x, fast_dt());
              send_byte(y, fast_ms + $urandom_range(0, 100));
            end
          endcase
        end else begin
          case ($urandom_range(0, 3))
            0: x = srsd_pkg::ResetByte;
            1: x = srsd_pkg::SyncLead;
            2: x = srsd_pkg::SyncOne;
            default: x = 8'($urandom);
          endcase
          send_byte(x, noise_dt());
        end
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
src/srsd_pkg.sv
src/srsd_front.sv
src/srsd_queue.sv
src/srsd_back.sv
src/serial_reset_sync_detector.sv
src/srsd_chk.sv
verif/srsd_checker.sv
verif/tb_top.sv
